[rtl/set_assoc_lru_cache_directory_macros.svh]
// Assertion macros shared by the cache directory modules
`ifndef SET_ASSOC_LRU_CACHE_DIRECTORY_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_DIRECTORY_MACROS_SVH

// Implication checked in the same cycle, on clk, quiet during rst
`define SACD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle, on clk, quiet during rst
`define SACD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sacd_pkg.sv]
// Types and constants of the set-associative cache directory
`default_nettype none

package sacd_pkg;

  // Geometry of the directory
  localparam int ADDR_W   = 26;
  localparam int MAX_WAYS = 8;
  localparam int MAX_SETS = 256;
  localparam int WAY_W    = 3;
  localparam int SET_W    = 8;
  localparam int TAG_W    = 24;
  localparam int RANK_W   = 3;
  localparam int BLK_W    = 24;
  localparam int CNT_W    = 32;

  // Configuration register widths and limits
  localparam int WAYS_W   = 4;
  localparam int IDXW_W   = 4;
  localparam int OFFW_W   = 3;
  localparam logic [IDXW_W-1:0] IDX_MAX = IDXW_W'(8);
  localparam logic [OFFW_W-1:0] OFF_MIN = OFFW_W'(2);
  localparam logic [OFFW_W-1:0] OFF_MAX = OFFW_W'(6);

  // APB port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_WAYS   = 2'd0;
  localparam logic [1:0] REG_INDEX  = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  // Access codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [RANK_W-1:0] rank_t;

  // One set of the directory: valid bits, tags and recency ranks of all ways
  typedef struct packed {
    logic [MAX_WAYS-1:0] valid;
    tag_t [MAX_WAYS-1:0] tag;
    rank_t [MAX_WAYS-1:0] rank;
  } row_t;

  // Effective (saturated) configuration
  typedef struct packed {
    logic [WAYS_W-1:0] ways;
    logic [IDXW_W-1:0] idx;
    logic [OFFW_W-1:0] off;
  } cfg_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic clear_wr;
    logic load_item;
    logic lookup;
    logic commit;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

[rtl/sacd_cfg.sv]
// APB configuration registers of the cache directory
`default_nettype none

module sacd_cfg
  import sacd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [WAYS_W-1:0] ways_in_use;
  logic [IDXW_W-1:0] index_width;
  logic [OFFW_W-1:0] offset_width;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use  <= WAYS_W'(4);
      index_width  <= IDXW_W'(4);
      offset_width <= OFFW_W'(4);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_WAYS:   ways_in_use  <= pwdata[WAYS_W-1:0];
        REG_INDEX:  index_width  <= pwdata[IDXW_W-1:0];
        REG_OFFSET: offset_width <= pwdata[OFFW_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register
  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_WAYS:   prdata = PDATA_W'(ways_in_use);
      REG_INDEX:  prdata = PDATA_W'(index_width);
      REG_OFFSET: prdata = PDATA_W'(offset_width);
      default:    prdata = '0;
    endcase
  end

  // Saturate fields into their working ranges
  always_comb begin
    if (ways_in_use == '0) begin
      cfg.ways = WAYS_W'(1);
    end else if (ways_in_use > WAYS_W'(MAX_WAYS)) begin
      cfg.ways = WAYS_W'(MAX_WAYS);
    end else begin
      cfg.ways = ways_in_use;
    end
    cfg.idx = (index_width > IDX_MAX) ? IDX_MAX : index_width;
    if (offset_width < OFF_MIN) begin
      cfg.off = OFF_MIN;
    end else if (offset_width > OFF_MAX) begin
      cfg.off = OFF_MAX;
    end else begin
      cfg.off = offset_width;
    end
  end

endmodule

`default_nettype wire

[rtl/sacd_ctrl.sv]
// Sequencer of the cache directory: clearing pass, lookup and commit
`default_nettype none
`include "set_assoc_lru_cache_directory_macros.svh"

module sacd_ctrl
  import sacd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decide the next state and the commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  `SACD_ASSERT_NEXT(a_accept_reads, in_valid && !in_stall, state == ST_READ,
    "accepted beat did not start a directory read")
  `SACD_ASSERT_NEXT(a_update_holds, state == ST_UPDATE && !sts.out_free, state == ST_UPDATE,
    "update left while the result register was occupied")
  `SACD_ASSERT_NEXT(a_clear_ends, state == ST_CLEAR && sts.clear_last, state == ST_IDLE,
    "clearing pass did not end after the last set")

endmodule

`default_nettype wire

[rtl/sacd_dpath.sv]
// Directory memory, tag compare, LRU update, counters and result register
`default_nettype none
`include "set_assoc_lru_cache_directory_macros.svh"

module sacd_dpath
  import sacd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              operation,
  input  wire logic [ADDR_W-1:0] byte_address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   hit,
  output logic      [WAY_W-1:0]  way_used,
  output logic                   fill_needed,
  output logic                   writeback_needed,
  output logic      [BLK_W-1:0]  writeback_block_address,
  output logic      [CNT_W-1:0]  hit_count,
  output logic      [CNT_W-1:0]  miss_count,
  output logic      [CNT_W-1:0]  memory_access_count
);

  row_t mem [MAX_SETS];

  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SET_W-1:0]  set_q;
  tag_t              tag_q;
  row_t              row_q;
  logic [SET_W-1:0]  clr_addr;

  logic [ADDR_W-1:0] set_shift;
  logic [ADDR_W-1:0] tag_shift;
  logic [4:0]        tag_amt;
  logic [SET_W:0]    idx_mask;
  logic [SET_W-1:0]  set_c;
  tag_t              tag_c;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    way_c;
  logic                hit_c;
  logic                found_c;
  logic                fill_c;
  logic                wb_c;
  rank_t               rank_way;
  logic [31:0]         blk_wide;
  logic [BLK_W-1:0]    wb_addr_c;
  row_t                row_n;

  logic [CNT_W-1:0] hits_seen;
  logic [CNT_W-1:0] misses_seen;
  logic [CNT_W-1:0] memory_transfers;

  // Report result register space and the end of the clearing pass
  always_comb begin
    sts.out_free   = !out_valid || !out_stall;
    sts.clear_last = (clr_addr == SET_W'(MAX_SETS - 1));
  end

  // Split the held address into set index and tag
  always_comb begin
    set_shift = addr_q >> cfg.off;
    idx_mask  = (SET_W + 1)'((1 << cfg.idx) - 1);
    set_c     = set_shift[SET_W-1:0] & idx_mask[SET_W-1:0];
    tag_amt   = 5'(cfg.off) + 5'(cfg.idx);
    tag_shift = addr_q >> tag_amt;
    tag_c     = tag_shift[TAG_W-1:0];
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= operation;
      addr_q <= byte_address;
    end
  end

  // Read the set and hold its index and tag
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      row_q <= mem[set_c];
      set_q <= set_c;
      tag_q <= tag_c;
    end
  end

  // Write the memory: zero rows during the clearing pass, updated set on commit
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.commit) begin
      mem[set_q] <= row_n;
    end
  end

  // Advance the clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  // Compare tags, pick the way and rebuild the set's recency ranks
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]   = WAYS_W'(i) < cfg.ways;
      hit_vec[i]  = in_use[i] && row_q.valid[i] && (row_q.tag[i] == tag_q);
      free_vec[i] = in_use[i] && !row_q.valid[i];
    end

    // lowest matching way and lowest free way
    hit_way  = '0;
    free_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (free_vec[i]) begin
        free_way = WAY_W'(i);
      end
    end

    // least recent way, lowest way on a tie
    victim = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (row_q.rank[i] < row_q.rank[victim])) begin
        victim = WAY_W'(i);
      end
    end

    hit_c   = |hit_vec;
    found_c = |free_vec;
    if (hit_c) begin
      way_c = hit_way;
    end else if (found_c) begin
      way_c = free_way;
    end else begin
      way_c = victim;
    end
    fill_c = !hit_c && ((op_q == OP_READ) || (cfg.off > OFF_MIN));
    wb_c   = !hit_c && !found_c;

    blk_wide  = (32'(row_q.tag[victim]) << cfg.idx) | 32'(set_q);
    wb_addr_c = wb_c ? blk_wide[BLK_W-1:0] : '0;

    // drop every valid way above the used way's old rank; a free fill drops all
    rank_way = row_q.rank[way_c];
    row_n    = row_q;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if ((WAY_W'(i) != way_c) && in_use[i] && row_q.valid[i] &&
          (row_q.rank[i] != '0) &&
          ((!hit_c && found_c) || (row_q.rank[i] > rank_way))) begin
        row_n.rank[i] = row_q.rank[i] - RANK_W'(1);
      end
    end
    row_n.rank[way_c] = RANK_W'(cfg.ways - WAYS_W'(1));
    if (!hit_c) begin
      row_n.tag[way_c]   = tag_q;
      row_n.valid[way_c] = 1'b1;
    end
  end

  // Advance the running counters on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      hits_seen        <= '0;
      misses_seen      <= '0;
      memory_transfers <= '0;
    end else if (cmd.commit) begin
      hits_seen        <= hits_seen + CNT_W'(hit_c);
      misses_seen      <= misses_seen + CNT_W'(!hit_c);
      memory_transfers <= memory_transfers + CNT_W'(fill_c) + CNT_W'(wb_c);
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.commit || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit                     <= hit_c;
      way_used                <= way_c;
      fill_needed             <= fill_c;
      writeback_needed        <= wb_c;
      writeback_block_address <= wb_addr_c;
    end
  end

  // Counters change only on commit, so they serve as result fields directly
  assign hit_count           = hits_seen;
  assign miss_count          = misses_seen;
  assign memory_access_count = memory_transfers;

  `SACD_ASSERT_NOW(a_hit_no_transfer, out_valid && hit,
    !fill_needed && !writeback_needed, "hit reported with a memory transfer")
  `SACD_ASSERT_NOW(a_idle_wb_addr, out_valid && !writeback_needed,
    writeback_block_address == '0, "block address set without a writeback")
  `SACD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(way_used) && $stable(hit_count), "stalled result beat changed")

endmodule

`default_nettype wire

[rtl/set_assoc_lru_cache_directory.sv]
// Top level of the set-associative cache tag and LRU directory
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | to block  | in_valid / in_stall    | operation, byte_address
//  out     | from block| out_valid / out_stall  | hit, way_used, fill_needed,
//          |           |                        | writeback_needed, writeback_block_address,
//          |           |                        | hit_count, miss_count, memory_access_count
//  cfg     | to block  | psel / penable / pready| paddr, pwdata, pwrite, prdata
//
// Each access goes through capture, a registered read of the set's row from the directory
// memory, then compare, LRU update and write-back of the row.
// After rst a clearing pass zeroes all 256 sets, one per cycle; in_stall stays high
// throughout the pass while configuration writes are still taken.
// A stalled result is held; the next access is accepted meanwhile and waits in its update
// cycle until the result register is free.
`default_nettype none

module set_assoc_lru_cache_directory
  import sacd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               operation,
  input  wire logic [ADDR_W-1:0]  byte_address,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hit,
  output logic      [WAY_W-1:0]   way_used,
  output logic                    fill_needed,
  output logic                    writeback_needed,
  output logic      [BLK_W-1:0]   writeback_block_address,
  output logic      [CNT_W-1:0]   hit_count,
  output logic      [CNT_W-1:0]   miss_count,
  output logic      [CNT_W-1:0]   memory_access_count
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  sacd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sacd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacd_dpath u_dpath (
    .clk                     (clk),
    .rst                     (rst),
    .cfg                     (cfg),
    .cmd                     (cmd),
    .sts                     (sts),
    .operation               (operation),
    .byte_address            (byte_address),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .hit                     (hit),
    .way_used                (way_used),
    .fill_needed             (fill_needed),
    .writeback_needed        (writeback_needed),
    .writeback_block_address (writeback_block_address),
    .hit_count               (hit_count),
    .miss_count              (miss_count),
    .memory_access_count     (memory_access_count)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the set-associative LRU cache directory
`timescale 1ns / 1ps

module testbench
  import sacd_pkg::*;
();

  localparam int SILENT_LIMIT = 3000;
  localparam int LINES        = MAX_WAYS * MAX_SETS;

  // One lookup outcome as the block reports it
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             fill;
    logic             wb;
    logic [BLK_W-1:0] wb_block;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] transfers;
  } lookup_outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = OP_READ;
  logic [ADDR_W-1:0]  byte_address = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic [WAY_W-1:0]   way_used;
  logic               fill_needed;
  logic               writeback_needed;
  logic [BLK_W-1:0]   writeback_block_address;
  logic [CNT_W-1:0]   hit_count;
  logic [CNT_W-1:0]   miss_count;
  logic [CNT_W-1:0]   memory_access_count;

  set_assoc_lru_cache_directory u_top (
    .clk                     (clk),
    .rst                     (rst),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .operation               (operation),
    .byte_address            (byte_address),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .hit                     (hit),
    .way_used                (way_used),
    .fill_needed             (fill_needed),
    .writeback_needed        (writeback_needed),
    .writeback_block_address (writeback_block_address),
    .hit_count               (hit_count),
    .miss_count              (miss_count),
    .memory_access_count     (memory_access_count)
  );

  always #5 clk = ~clk;

  // Shadow directory: raw register copies, lines and counters
  logic [WAYS_W-1:0] cfg_ways   = 4'd4;
  logic [IDXW_W-1:0] cfg_index  = 4'd4;
  logic [OFFW_W-1:0] cfg_offset = 3'd4;
  bit                dir_valid [LINES];
  bit [TAG_W-1:0]    dir_tag   [LINES];
  bit [RANK_W-1:0]   dir_rank  [LINES];
  logic [CNT_W-1:0]  hits_total      = '0;
  logic [CNT_W-1:0]  misses_total    = '0;
  logic [CNT_W-1:0]  transfers_total = '0;

  lookup_outcome_t pending_lookups [$];

  // Stimulus shaping
  bit               in_quiet = 1'b0;
  int unsigned      hot_sets [4];
  logic [TAG_W-1:0] tag_pool [10];
  int unsigned      pool_size = 6;

  // Run statistics
  int mismatch_count   = 0;
  int accesses_sent    = 0;
  int geometries       = 1;
  int hits_seen_tb     = 0;
  int writebacks_seen  = 0;
  int nofill_writes    = 0;
  int silent_cycles    = 0;
  int unsigned stall_left = 0;

  function automatic int unsigned ways_active();
    if (cfg_ways < 1) return 1;
    if (cfg_ways > MAX_WAYS) return MAX_WAYS;
    return cfg_ways;
  endfunction

  function automatic int unsigned offset_active();
    if (cfg_offset < OFF_MIN) return OFF_MIN;
    if (cfg_offset > OFF_MAX) return OFF_MAX;
    return cfg_offset;
  endfunction

  function automatic int unsigned index_active();
    if (cfg_index > IDX_MAX) return IDX_MAX;
    return cfg_index;
  endfunction

  // Make way w newest; old_rank is -1 for a line that was just filled
  function automatic void raise_to_newest(int unsigned base, int unsigned nways,
                                          int unsigned w, int old_rank);
    int unsigned i;
    for (i = 0; i < nways; i++) begin
      if (i != w && dir_valid[base+i] && int'(dir_rank[base+i]) > old_rank &&
          dir_rank[base+i] > 0)
        dir_rank[base+i] = dir_rank[base+i] - RANK_W'(1);
    end
    dir_rank[base+w] = RANK_W'(nways - 1);
  endfunction

  // Look the access up in the shadow directory and update it
  function automatic lookup_outcome_t predict_lookup(input logic op,
                                                     input logic [ADDR_W-1:0] addr);
    lookup_outcome_t  r;
    int unsigned      nways, off, idx, set, base, w, best, i;
    logic [TAG_W-1:0] tg;
    bit               matched, free_found;
    longint unsigned  blk;
    nways = ways_active();
    off   = offset_active();
    idx   = index_active();
    set   = (addr >> off) & ((1 << idx) - 1);
    tg    = TAG_W'(addr >> (off + idx));
    base  = set * MAX_WAYS;
    r     = '0;
    matched = 1'b0;
    free_found = 1'b0;
    w = 0;
    for (i = 0; i < nways; i++) begin
      if (!matched && dir_valid[base+i] && dir_tag[base+i] == tg) begin
        matched = 1'b1;
        w = i;
      end
    end
    if (matched) begin
      hits_total = hits_total + 1;
      raise_to_newest(base, nways, w, int'(dir_rank[base+w]));
    end else begin
      misses_total = misses_total + 1;
      r.fill = (op == OP_WRITE) ? (off > 2) : 1'b1;
      for (i = 0; i < nways; i++) begin
        if (!free_found && !dir_valid[base+i]) begin
          free_found = 1'b1;
          w = i;
        end
      end
      if (free_found) begin
        dir_valid[base+w] = 1'b1;
        dir_tag[base+w]   = tg;
        raise_to_newest(base, nways, w, -1);
      end else begin
        // full set: oldest rank goes, lowest way on a tie
        best = 0;
        for (i = 1; i < nways; i++)
          if (dir_rank[base+i] < dir_rank[base+best]) best = i;
        w = best;
        r.wb = 1'b1;
        blk = (longint'(dir_tag[base+w]) << idx) | set;
        r.wb_block = BLK_W'(blk);
        dir_tag[base+w] = tg;
        raise_to_newest(base, nways, w, int'(dir_rank[base+w]));
      end
      transfers_total = transfers_total + r.fill + r.wb;
    end
    r.hit       = matched;
    r.way       = WAY_W'(w);
    r.hits      = hits_total;
    r.misses    = misses_total;
    r.transfers = transfers_total;
    return r;
  endfunction

  // Sender gap: mostly none or short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (in_quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Hot sets and a small tag pool give hits and evictions; the rest is noise
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned     off, idx;
    longint unsigned v;
    off = offset_active();
    idx = index_active();
    if ($urandom_range(0, 99) < 12) return ADDR_W'($urandom);
    v = (longint'(tag_pool[$urandom_range(0, pool_size - 1)]) << (off + idx)) |
        (longint'(hot_sets[$urandom_range(0, 3)]) << off) |
        longint'($urandom_range(0, (1 << off) - 1));
    return ADDR_W'(v);
  endfunction

  // Present one access beat and wait until it is taken
  task automatic issue_access(input logic op, input logic [ADDR_W-1:0] addr);
    int unsigned pause;
    pause = idle_gap();
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    byte_address <= addr;
    do @(posedge clk); while (in_stall);
    pending_lookups.push_back(predict_lookup(op, addr));
    accesses_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic await_quiet();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back
  task automatic program_geometry(input logic [WAYS_W-1:0] ways,
                                  input logic [IDXW_W-1:0] idx,
                                  input logic [OFFW_W-1:0] off);
    logic [1:0]         regs [3];
    logic [PDATA_W-1:0] vals [3];
    int                 i;
    regs = '{REG_WAYS, REG_INDEX, REG_OFFSET};
    vals = '{PDATA_W'(ways), PDATA_W'(idx), PDATA_W'(off)};
    for (i = 0; i < 3; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[i], 2'b00};
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_ways   = ways;
    cfg_index  = idx;
    cfg_offset = off;
    geometries++;
  endtask

  // Random accesses over a fresh set of hot sets and tags
  task automatic run_random_burst(input int count);
    int i;
    pool_size = ways_active() + 2;
    for (i = 0; i < 4; i++) hot_sets[i] = $urandom_range(0, (1 << index_active()) - 1);
    for (i = 0; i < 10; i++) tag_pool[i] = TAG_W'($urandom);
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) in_quiet = ($urandom_range(0, 3) == 0);
      issue_access(logic'($urandom_range(0, 1)), pick_address());
    end
    in_quiet = 1'b0;
  endtask

  // Default geometry: fill a set, hit, evict, then address extremes
  task automatic test_reset_geometry();
    issue_access(OP_READ,  26'h0000000);
    issue_access(OP_READ,  26'h000000F);
    issue_access(OP_WRITE, {18'd1, 4'd0, 4'd4});
    issue_access(OP_READ,  {18'd2, 4'd0, 4'd8});
    issue_access(OP_WRITE, {18'd3, 4'd0, 4'd0});
    issue_access(OP_READ,  {18'd0, 4'd0, 4'd3});
    issue_access(OP_READ,  {18'd4, 4'd0, 4'd0});
    issue_access(OP_WRITE, {18'd1, 4'd0, 4'd0});
    issue_access(OP_READ,  26'h3FFFFFF);
    issue_access(OP_WRITE, 26'h3FFFFF0);
    issue_access(OP_WRITE, 26'h2AAAAAA);
    issue_access(OP_READ,  26'h1555555);
    run_random_burst(150);
    await_quiet();
  endtask

  // Direct-mapped, one set, word lines: write misses go without a fill
  task automatic test_word_lines();
    program_geometry(4'd1, 4'd0, 3'd2);
    issue_access(OP_WRITE, 26'h0000004);
    issue_access(OP_WRITE, 26'h0000004);
    issue_access(OP_WRITE, 26'h0000008);
    issue_access(OP_READ,  26'h000000C);
    issue_access(OP_READ,  26'h3FFFFFC);
    run_random_burst(60);
    await_quiet();
  endtask

  // Walk through geometries, out-of-range values among them; lines stay valid
  task automatic test_geometry_sweep();
    logic [WAYS_W-1:0] ways_tab [7];
    logic [IDXW_W-1:0] idx_tab  [7];
    logic [OFFW_W-1:0] off_tab  [7];
    int                k;
    ways_tab = '{4'd8, 4'd0,  4'd15, 4'd3, 4'd2, 4'd8, 4'd5};
    idx_tab  = '{4'd8, 4'd15, 4'd2,  4'd1, 4'd3, 4'd0, 4'd6};
    off_tab  = '{3'd6, 3'd7,  3'd1,  3'd3, 3'd0, 3'd5, 3'd2};
    for (k = 0; k < 7; k++) begin
      program_geometry(ways_tab[k], idx_tab[k], off_tab[k]);
      run_random_burst(130);
      await_quiet();
    end
  endtask

  // Receiver stalls: runs of free flow and of stall, short and long
  always @(posedge clk) begin : stall_pattern
    int unsigned roll;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(20, 60);
      end else if (roll < 75) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else if (roll < 95) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 30);
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    lookup_outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        $error("result beat with no access outstanding");
        mismatch_count++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("hit", want.hit, hit);
        check_field("way_used", want.way, way_used);
        check_field("fill_needed", want.fill, fill_needed);
        check_field("writeback_needed", want.wb, writeback_needed);
        check_field("writeback_block_address", want.wb_block, writeback_block_address);
        check_field("hit_count", want.hits, hit_count);
        check_field("miss_count", want.misses, miss_count);
        check_field("memory_access_count", want.transfers, memory_access_count);
        if (want.hit) hits_seen_tb++;
        if (want.wb) writebacks_seen++;
        if (!want.hit && !want.fill) nofill_writes++;
      end
    end
  end

  // Count cycles with no beat or register write on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready))
      silent_cycles <= 0;
    else
      silent_cycles <= silent_cycles + 1;
  end

  initial begin : watchdog
    wait (silent_cycles >= SILENT_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_geometry();
    test_word_lines();
    test_geometry_sweep();
    await_quiet();
    repeat (20) @(posedge clk);
    $display("Covered %0d accesses over %0d geometries, reset defaults and saturated values",
             accesses_sent, geometries);
    $display("Observed %0d hits, %0d write-backs, %0d write misses without fill",
             hits_seen_tb, writebacks_seen, nofill_writes);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
